[src/sabv_pkg.sv]
// ----------------------------------------------------------------------------
// sabv_pkg
// shared types and constants of the signed angle between vectors block
// ----------------------------------------------------------------------------
package sabv_pkg;

    localparam int ANGLE_BITS = 9;
    localparam int FRAC_BITS  = 16;
    localparam int NORM_MSB   = 29;
    localparam int NORM_BITS  = NORM_MSB + 1;
    localparam int XY_BITS    = 34;
    localparam int Z_BITS     = 26;
    localparam int TABLE_LEN  = 24;
    localparam int TABLE_BITS = 23;

    localparam logic signed [Z_BITS-1:0] RIGHT_ANGLE = Z_BITS'(90 << FRAC_BITS);
    localparam logic signed [Z_BITS-1:0] HALF_TURN   = Z_BITS'(180 << FRAC_BITS);

    // atan(2^-i) in degrees, 16 fraction bits
    localparam logic [TABLE_BITS-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

    typedef struct packed {
        logic degenerate;
        logic cross_zero;
        logic dot_zero;
        logic cross_neg;
        logic dot_neg;
    } sabv_flags_t;

endpackage

[src/signed_angle_between_vectors.sv]
// ----------------------------------------------------------------------------
// signed_angle_between_vectors
// signed angle at a vertex, atan2(cross, dot) in whole degrees
//
// a transaction is taken at a rising edge with start high and busy low; busy
// stays low, so a new point triple can be given in every cycle. the points
// are first, center and second, each coordinate signed Q12.4.
// the result (angle_degrees, -180..180 truncated toward zero, and
// degenerate for a zero-length vector) is on the ports for one cycle while
// done is high. between the accepting edge and the result lie these
// registered stages in order: differences, products, sums, magnitudes,
// leading-one search, normalizing shift, one stage per angle iteration
// and the output register. throughput is one transaction per cycle, set
// by the fully unrolled iteration pipeline. results leave in the order
// the transactions came in. reset clears all valid bits, so nothing in
// flight comes out; the receiver cannot stall and every result is shown
// exactly once.
// ----------------------------------------------------------------------------
module signed_angle_between_vectors #(
    parameter int COORD_BITS       = 16,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [COORD_BITS-1:0]           first_x,
    input  logic signed [COORD_BITS-1:0]           first_y,
    input  logic signed [COORD_BITS-1:0]           center_x,
    input  logic signed [COORD_BITS-1:0]           center_y,
    input  logic signed [COORD_BITS-1:0]           second_x,
    input  logic signed [COORD_BITS-1:0]           second_y,
    output logic                                   done,
    output logic signed [sabv_pkg::ANGLE_BITS-1:0] angle_degrees,
    output logic                                   degenerate
);

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS  = PROD_BITS;
    localparam int LATENCY   = ANGLE_ITERATIONS + 7;

    // stage 1: vectors from the center
    logic                         s1_valid_reg;
    logic signed [DIFF_BITS-1:0]  ax_reg;
    logic signed [DIFF_BITS-1:0]  ay_reg;
    logic signed [DIFF_BITS-1:0]  bx_reg;
    logic signed [DIFF_BITS-1:0]  by_reg;

    // stage 2: products
    logic                         s2_valid_reg;
    logic                         s2_degen_reg;
    logic signed [PROD_BITS-1:0]  bxay_reg;
    logic signed [PROD_BITS-1:0]  axby_reg;
    logic signed [PROD_BITS-1:0]  bxax_reg;
    logic signed [PROD_BITS-1:0]  byay_reg;
    logic signed [PROD_BITS-1:0]  bxay_next;
    logic signed [PROD_BITS-1:0]  axby_next;
    logic signed [PROD_BITS-1:0]  bxax_next;
    logic signed [PROD_BITS-1:0]  byay_next;
    logic                         s2_degen_next;

    // stage 3: cross and dot
    logic                         s3_valid_reg;
    logic                         s3_degen_reg;
    logic signed [SUM_BITS-1:0]   cross_reg;
    logic signed [SUM_BITS-1:0]   dot_reg;

    // stage 4: magnitudes and signs
    logic                         s4_valid_reg;
    sabv_pkg::sabv_flags_t        s4_flags_reg;
    logic [MAG_BITS-1:0]          dot_mag_reg;
    logic [MAG_BITS-1:0]          cross_mag_reg;
    sabv_pkg::sabv_flags_t        s4_flags_next;
    logic [SUM_BITS-1:0]          dot_abs;
    logic [SUM_BITS-1:0]          cross_abs;

    // normalizer outputs
    logic                                norm_valid;
    sabv_pkg::sabv_flags_t               norm_flags;
    logic [sabv_pkg::NORM_BITS-1:0]      dot_norm;
    logic [sabv_pkg::NORM_BITS-1:0]      cross_norm;

    // iteration chain
    logic                                 chain_valid [0:ANGLE_ITERATIONS];
    sabv_pkg::sabv_flags_t                chain_flags [0:ANGLE_ITERATIONS];
    logic signed [sabv_pkg::XY_BITS-1:0]  chain_x     [0:ANGLE_ITERATIONS];
    logic signed [sabv_pkg::XY_BITS-1:0]  chain_y     [0:ANGLE_ITERATIONS];
    logic signed [sabv_pkg::Z_BITS-1:0]   chain_z     [0:ANGLE_ITERATIONS];

    // output stage
    logic                                   done_reg;
    logic signed [sabv_pkg::ANGLE_BITS-1:0] angle_reg;
    logic                                   degen_reg;
    logic signed [sabv_pkg::ANGLE_BITS-1:0] angle_next;
    sabv_pkg::sabv_flags_t                  end_flags;
    logic signed [sabv_pkg::Z_BITS-1:0]     phi;
    logic signed [sabv_pkg::Z_BITS-1:0]     mag;
    logic [sabv_pkg::ANGLE_BITS-1:0]        deg;
    logic                                   angle_neg;

    assign busy = 1'b0;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= chain_valid[ANGLE_ITERATIONS];
        end
    end

    always_comb
    begin
        bxay_next     = bx_reg * ay_reg;
        axby_next     = ax_reg * by_reg;
        bxax_next     = bx_reg * ax_reg;
        byay_next     = by_reg * ay_reg;
        s2_degen_next = (ax_reg == '0 && ay_reg == '0) || (bx_reg == '0 && by_reg == '0);
    end

    always_comb
    begin
        dot_abs   = dot_reg[SUM_BITS-1] ? SUM_BITS'(-dot_reg) : SUM_BITS'(dot_reg);
        cross_abs = cross_reg[SUM_BITS-1] ? SUM_BITS'(-cross_reg) : SUM_BITS'(cross_reg);
        s4_flags_next.degenerate = s3_degen_reg;
        s4_flags_next.cross_zero = (cross_reg == '0);
        s4_flags_next.dot_zero   = (dot_reg == '0);
        s4_flags_next.cross_neg  = cross_reg[SUM_BITS-1];
        s4_flags_next.dot_neg    = dot_reg[SUM_BITS-1];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ax_reg        <= DIFF_BITS'(first_x) - DIFF_BITS'(center_x);
        ay_reg        <= DIFF_BITS'(first_y) - DIFF_BITS'(center_y);
        bx_reg        <= DIFF_BITS'(second_x) - DIFF_BITS'(center_x);
        by_reg        <= DIFF_BITS'(second_y) - DIFF_BITS'(center_y);
        bxay_reg      <= bxay_next;
        axby_reg      <= axby_next;
        bxax_reg      <= bxax_next;
        byay_reg      <= byay_next;
        s2_degen_reg  <= s2_degen_next;
        cross_reg     <= SUM_BITS'(bxay_reg) - SUM_BITS'(axby_reg);
        dot_reg       <= SUM_BITS'(bxax_reg) + SUM_BITS'(byay_reg);
        s3_degen_reg  <= s2_degen_reg;
        s4_flags_reg  <= s4_flags_next;
        dot_mag_reg   <= dot_abs[MAG_BITS-1:0];
        cross_mag_reg <= cross_abs[MAG_BITS-1:0];
        angle_reg     <= angle_next;
        degen_reg     <= end_flags.degenerate;
    end

    sabv_norm #(
        .MAG_BITS (MAG_BITS)
    ) u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s4_valid_reg),
        .in_flags   (s4_flags_reg),
        .dot_mag    (dot_mag_reg),
        .cross_mag  (cross_mag_reg),
        .out_valid  (norm_valid),
        .out_flags  (norm_flags),
        .dot_norm   (dot_norm),
        .cross_norm (cross_norm)
    );

    assign chain_valid[0] = norm_valid;
    assign chain_flags[0] = norm_flags;
    assign chain_x[0]     = signed'(sabv_pkg::XY_BITS'(dot_norm));
    assign chain_y[0]     = signed'(sabv_pkg::XY_BITS'(cross_norm));
    assign chain_z[0]     = '0;

    for (genvar i = 0; i < ANGLE_ITERATIONS; i++)
    begin : g_iter
        sabv_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_flags  (chain_flags[i]),
            .x_in      (chain_x[i]),
            .y_in      (chain_y[i]),
            .z_in      (chain_z[i]),
            .out_valid (chain_valid[i+1]),
            .out_flags (chain_flags[i+1]),
            .x_out     (chain_x[i+1]),
            .y_out     (chain_y[i+1]),
            .z_out     (chain_z[i+1])
        );
    end

    // quadrant and sign
    always_comb
    begin
        end_flags = chain_flags[ANGLE_ITERATIONS];
        priority if (end_flags.cross_zero)
        begin
            phi = '0;
        end
        else if (end_flags.dot_zero)
        begin
            phi = sabv_pkg::RIGHT_ANGLE;
        end
        else if (chain_z[ANGLE_ITERATIONS] < sabv_pkg::Z_BITS'(1))
        begin
            phi = sabv_pkg::Z_BITS'(1);
        end
        else if (chain_z[ANGLE_ITERATIONS] > sabv_pkg::RIGHT_ANGLE - sabv_pkg::Z_BITS'(1))
        begin
            phi = sabv_pkg::RIGHT_ANGLE - sabv_pkg::Z_BITS'(1);
        end
        else
        begin
            phi = chain_z[ANGLE_ITERATIONS];
        end
        mag = end_flags.dot_neg ? (sabv_pkg::HALF_TURN - phi) : phi;
        deg = mag[sabv_pkg::FRAC_BITS +: sabv_pkg::ANGLE_BITS];
        angle_neg = end_flags.cross_neg || (end_flags.cross_zero && end_flags.dot_neg);
        if (end_flags.degenerate)
        begin
            angle_next = '0;
        end
        else if (angle_neg)
        begin
            angle_next = signed'(-deg);
        end
        else
        begin
            angle_next = signed'(deg);
        end
    end

    assign done          = done_reg;
    assign angle_degrees = angle_reg;
    assign degenerate    = degen_reg;

    a_done_from_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY)
    ) else $error("result without a matching transaction");

    a_start_gives_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done
    ) else $error("transaction lost in the pipeline");

    a_zero_vector: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && first_x == center_x && first_y == center_y) |->
            ##LATENCY (done && degenerate && angle_degrees == '0)
    ) else $error("zero-length vector not flagged");

    a_angle_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (angle_degrees >= -9'sd180 && angle_degrees <= 9'sd180)
    ) else $error("angle out of range");

endmodule

[src/sabv_norm.sv]
// ----------------------------------------------------------------------------
// sabv_norm
// two-stage normalizer: leading-one search, then common shift of both
// magnitudes so that the larger lands in [2^29, 2^30)
// ----------------------------------------------------------------------------
module sabv_norm #(
    parameter int MAG_BITS = 34
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  sabv_pkg::sabv_flags_t             in_flags,
    input  logic [MAG_BITS-1:0]               dot_mag,
    input  logic [MAG_BITS-1:0]               cross_mag,
    output logic                              out_valid,
    output sabv_pkg::sabv_flags_t             out_flags,
    output logic [sabv_pkg::NORM_BITS-1:0]    dot_norm,
    output logic [sabv_pkg::NORM_BITS-1:0]    cross_norm
);

    localparam int POS_BITS  = $clog2(MAG_BITS);
    localparam int WIDE_BITS = MAG_BITS + sabv_pkg::NORM_BITS;

    logic                        a_valid_reg;
    sabv_pkg::sabv_flags_t       a_flags_reg;
    logic [MAG_BITS-1:0]         a_dot_reg;
    logic [MAG_BITS-1:0]         a_cross_reg;
    logic [POS_BITS-1:0]         a_pos_reg;
    logic [POS_BITS-1:0]         a_pos_next;
    logic [MAG_BITS-1:0]         or_mag;

    logic                        b_valid_reg;
    sabv_pkg::sabv_flags_t       b_flags_reg;
    logic [sabv_pkg::NORM_BITS-1:0] b_dot_reg;
    logic [sabv_pkg::NORM_BITS-1:0] b_cross_reg;
    logic [sabv_pkg::NORM_BITS-1:0] b_dot_next;
    logic [sabv_pkg::NORM_BITS-1:0] b_cross_next;

    logic [POS_BITS:0]           pos_w;
    logic [POS_BITS:0]           norm_top;
    logic [WIDE_BITS-1:0]        dot_w;
    logic [WIDE_BITS-1:0]        cross_w;
    logic [WIDE_BITS-1:0]        dot_s;
    logic [WIDE_BITS-1:0]        cross_s;

    // highest set bit of either magnitude
    always_comb
    begin
        or_mag     = dot_mag | cross_mag;
        a_pos_next = '0;
        for (int i = 0; i < MAG_BITS; i++)
        begin
            if (or_mag[i])
            begin
                a_pos_next = POS_BITS'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_flags_reg <= in_flags;
        a_dot_reg   <= dot_mag;
        a_cross_reg <= cross_mag;
        a_pos_reg   <= a_pos_next;
        b_flags_reg <= a_flags_reg;
        b_dot_reg   <= b_dot_next;
        b_cross_reg <= b_cross_next;
    end

    always_comb
    begin
        pos_w    = {1'b0, a_pos_reg};
        norm_top = (POS_BITS + 1)'(sabv_pkg::NORM_MSB);
        dot_w    = WIDE_BITS'(a_dot_reg);
        cross_w  = WIDE_BITS'(a_cross_reg);
        if (pos_w >= norm_top)
        begin
            dot_s   = dot_w >> (pos_w - norm_top);
            cross_s = cross_w >> (pos_w - norm_top);
        end
        else
        begin
            dot_s   = dot_w << (norm_top - pos_w);
            cross_s = cross_w << (norm_top - pos_w);
        end
        b_dot_next   = dot_s[sabv_pkg::NORM_BITS-1:0];
        b_cross_next = cross_s[sabv_pkg::NORM_BITS-1:0];
    end

    assign out_valid  = b_valid_reg;
    assign out_flags  = b_flags_reg;
    assign dot_norm   = b_dot_reg;
    assign cross_norm = b_cross_reg;

endmodule

[src/sabv_cordic_stage.sv]
// ----------------------------------------------------------------------------
// sabv_cordic_stage
// one registered vectoring iteration of the angle pipeline
// ----------------------------------------------------------------------------
module sabv_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  sabv_pkg::sabv_flags_t                 in_flags,
    input  logic signed [sabv_pkg::XY_BITS-1:0]   x_in,
    input  logic signed [sabv_pkg::XY_BITS-1:0]   y_in,
    input  logic signed [sabv_pkg::Z_BITS-1:0]    z_in,
    output logic                                  out_valid,
    output sabv_pkg::sabv_flags_t                 out_flags,
    output logic signed [sabv_pkg::XY_BITS-1:0]   x_out,
    output logic signed [sabv_pkg::XY_BITS-1:0]   y_out,
    output logic signed [sabv_pkg::Z_BITS-1:0]    z_out
);

    logic                                 valid_reg;
    sabv_pkg::sabv_flags_t                flags_reg;
    logic signed [sabv_pkg::XY_BITS-1:0]  x_reg;
    logic signed [sabv_pkg::XY_BITS-1:0]  y_reg;
    logic signed [sabv_pkg::Z_BITS-1:0]   z_reg;
    logic signed [sabv_pkg::XY_BITS-1:0]  x_next;
    logic signed [sabv_pkg::XY_BITS-1:0]  y_next;
    logic signed [sabv_pkg::Z_BITS-1:0]   z_next;
    logic signed [sabv_pkg::XY_BITS-1:0]  xs;
    logic signed [sabv_pkg::XY_BITS-1:0]  ys;
    logic signed [sabv_pkg::Z_BITS-1:0]   step;

    always_comb
    begin
        xs   = x_in >>> SHIFT;
        ys   = y_in >>> SHIFT;
        step = signed'(sabv_pkg::Z_BITS'(sabv_pkg::ATAN_TABLE[SHIFT]));
        if (!y_in[sabv_pkg::XY_BITS-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + step;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= in_flags;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule
